// File: design/crc_ec_pkg.sv
// ----------------------------------------------------------------------------
// crc_ec_pkg
// shared types and constants for the cyclic-code encoder and checker
// ----------------------------------------------------------------------------
package crc_ec_pkg;

	localparam int WORD_BITS       = 64;
	localparam int REM_BITS        = 32;
	localparam int DIV_STAGES      = 8;
	localparam int STEPS_PER_STAGE = WORD_BITS / DIV_STAGES;

	localparam int MAX_DEGREE_DEF  = 32;
	localparam int DATA_BITS_DEF   = 32;

	localparam int GEN_DEGREE_BITS = 6;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_ADDR_BITS   = 3;

	localparam logic [31:0]                GEN_LOW_RESET    = 32'd7;
	localparam logic [GEN_DEGREE_BITS-1:0] GEN_DEGREE_RESET = 6'd8;

	localparam logic REG_GEN_LOW    = 1'b0;
	localparam logic REG_GEN_DEGREE = 1'b1;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_CHECK  = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic [WORD_BITS-1:0] word_in;
	} in_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] codeword;
		logic [REM_BITS-1:0]  remainder;
		logic                 error_flag;
		logic                 too_wide;
	} out_t;

	typedef struct packed {
		logic                 cmd;
		logic                 too_wide;
		logic [WORD_BITS-1:0] dividend;
	} pipe_t;

endpackage

// File: design/crc_ec_div_stage.sv
// ----------------------------------------------------------------------------
// crc_ec_div_stage
// one pipeline stage of the modulo-2 division, a fixed run of dividend bits
// ----------------------------------------------------------------------------
module crc_ec_div_stage #(
	parameter int WIDTH     = crc_ec_pkg::MAX_DEGREE_DEF,
	parameter int FIRST_BIT = crc_ec_pkg::WORD_BITS - 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  crc_ec_pkg::pipe_t  item_in,
	input  logic [WIDTH-1:0]   rem_in,
	input  logic [WIDTH-1:0]   ins_bit,
	input  logic [WIDTH-1:0]   low_al,
	output logic               valid_out,
	output crc_ec_pkg::pipe_t  item_out,
	output logic [WIDTH-1:0]   rem_out
);

	logic              valid_s;
	crc_ec_pkg::pipe_t item_s;
	logic [WIDTH-1:0]  rem_s;
	logic [WIDTH-1:0]  rem_next;

	// remainder kept aligned to the top bit, new dividend bit enters at ins_bit
	always_comb begin
		logic [WIDTH-1:0] r;
		logic             top;
		r = rem_in;
		for (int j = 0; j < crc_ec_pkg::STEPS_PER_STAGE; j++) begin
			top = r[WIDTH-1];
			r = (r << 1) | (item_in.dividend[FIRST_BIT-j] ? ins_bit : '0);
			if (top) begin
				r = r ^ low_al;
			end
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s <= item_in;
			rem_s  <= rem_next;
		end
	end

	assign valid_out = valid_s;
	assign item_out  = item_s;
	assign rem_out   = rem_s;

endmodule

// File: design/crc_encode_and_check.sv
// ----------------------------------------------------------------------------
// crc_encode_and_check
// cyclic-code encoder and checker with a programmable generator polynomial
// ----------------------------------------------------------------------------
//  channel   direction  payload   handshake
//  in        input      in_t      in_valid / in_stall
//  out       output     out_t     out_valid / out_stall
//  config    input      32 bit    apb write at psel & penable & pwrite
//
//  one beat per cycle while the pipeline is not held; one prep stage, eight division
//  stages of eight dividend bits each, one output stage
//  the whole pipeline holds while out_valid and out_stall are both high
//  reset clears valid bits and loads the generator x^8 + x^2 + x + 1
// ----------------------------------------------------------------------------
module crc_encode_and_check #(
	parameter int MAX_DEGREE = crc_ec_pkg::MAX_DEGREE_DEF,
	parameter int DATA_BITS  = crc_ec_pkg::DATA_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  crc_ec_pkg::in_t                        in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output crc_ec_pkg::out_t                       out_data,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [crc_ec_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [crc_ec_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [crc_ec_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                   pready
);

	localparam int W  = MAX_DEGREE;
	localparam int DB = crc_ec_pkg::GEN_DEGREE_BITS;
	localparam int NS = crc_ec_pkg::DIV_STAGES;

	logic [31:0]   gen_low_q;
	logic [DB-1:0] gen_degree_q;

	logic          en;
	logic [DB-1:0] deg_eff;
	logic [DB-1:0] sh;
	logic [W-1:0]  ins_bit;
	logic [W-1:0]  low_al;

	logic                          valid_st [0:NS];
	crc_ec_pkg::pipe_t             item_st  [0:NS];
	logic [W-1:0]                  rem_st   [0:NS];

	logic                          valid_s1;
	crc_ec_pkg::pipe_t             item_s1;
	crc_ec_pkg::pipe_t             prep;

	logic [W-1:0]                  rem_fin;
	logic [crc_ec_pkg::REM_BITS-1:0] rem_out;

	logic                          valid_s10;
	crc_ec_pkg::out_t              out_s10;
	crc_ec_pkg::out_t              out_next;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_low_q    <= crc_ec_pkg::GEN_LOW_RESET;
			gen_degree_q <= crc_ec_pkg::GEN_DEGREE_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				crc_ec_pkg::REG_GEN_LOW:    gen_low_q    <= pwdata;
				crc_ec_pkg::REG_GEN_DEGREE: gen_degree_q <= pwdata[DB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			crc_ec_pkg::REG_GEN_LOW:    prdata = gen_low_q;
			crc_ec_pkg::REG_GEN_DEGREE: prdata = 32'(gen_degree_q);
			default:                    prdata = '0;
		endcase
	end

	// generator terms aligned to the top of the remainder register
	always_comb begin
		if (gen_degree_q == '0) begin
			deg_eff = DB'(1);
		end else if (gen_degree_q > DB'(W)) begin
			deg_eff = DB'(W);
		end else begin
			deg_eff = gen_degree_q;
		end
		sh     = DB'(W) - deg_eff;
		low_al = W'(gen_low_q[W-1:0] << sh);
		for (int i = 0; i < W; i++) begin
			ins_bit[i] = (DB'(i) == sh);
		end
	end

	// pipeline control
	assign en       = !(valid_s10 && out_stall);
	assign in_stall = valid_s10 && out_stall;

	// prep stage
	always_comb begin
		prep.cmd = in_data.cmd;
		if (in_data.cmd == crc_ec_pkg::CMD_ENCODE) begin
			prep.dividend = crc_ec_pkg::WORD_BITS'(in_data.word_in[DATA_BITS-1:0]) << deg_eff;
			prep.too_wide = |(in_data.word_in >> DATA_BITS);
		end else begin
			prep.dividend = in_data.word_in;
			prep.too_wide = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= prep;
		end
	end

	assign valid_st[0] = valid_s1;
	assign item_st[0]  = item_s1;
	assign rem_st[0]   = '0;

	// division stages
	for (genvar k = 0; k < NS; k++) begin : g_div
		crc_ec_div_stage #(
			.WIDTH     (W),
			.FIRST_BIT (crc_ec_pkg::WORD_BITS - 1 - k * crc_ec_pkg::STEPS_PER_STAGE)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_st[k]),
			.item_in   (item_st[k]),
			.rem_in    (rem_st[k]),
			.ins_bit   (ins_bit),
			.low_al    (low_al),
			.valid_out (valid_st[k+1]),
			.item_out  (item_st[k+1]),
			.rem_out   (rem_st[k+1])
		);
	end

	// output stage
	always_comb begin
		rem_fin = rem_st[NS] >> sh;
		rem_out = crc_ec_pkg::REM_BITS'(rem_fin);
		out_next.remainder = rem_out;
		if (item_st[NS].cmd == crc_ec_pkg::CMD_ENCODE) begin
			out_next.codeword   = item_st[NS].dividend | crc_ec_pkg::WORD_BITS'(rem_out);
			out_next.error_flag = 1'b0;
			out_next.too_wide   = item_st[NS].too_wide;
		end else begin
			out_next.codeword   = '0;
			out_next.error_flag = |rem_out;
			out_next.too_wide   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s10 <= valid_st[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s10 <= out_next;
		end
	end

	assign out_valid = valid_s10;
	assign out_data  = out_s10;

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cyclic-code encoder and checker: beats go in
// through a stall-aware driver, every accepted beat is predicted by a bit-level
// modulo-2 divider, and each result beat is compared field by field in order;
// the generator is reprogrammed over apb between phases, extremes included
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W      = crc_ec_pkg::DATA_BITS_DEF;
	localparam int DEG_MAX     = crc_ec_pkg::MAX_DEGREE_DEF;
	localparam int DGB         = crc_ec_pkg::GEN_DEGREE_BITS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BEATS = 74;
	localparam int DRAIN_WAIT  = 12;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	crc_ec_pkg::in_t          in_data = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	crc_ec_pkg::out_t         out_data;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [crc_ec_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
	logic [crc_ec_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
	logic [crc_ec_pkg::CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	crc_ec_pkg::in_t          pending_words[$];
	crc_ec_pkg::out_t         crc_expected[$];
	logic [31:0]              cfg_low_terms = crc_ec_pkg::GEN_LOW_RESET;
	logic [DGB-1:0]           cfg_degree = crc_ec_pkg::GEN_DEGREE_RESET;
	int                       idle_pct = 26;
	bit                       in_taken = 1'b0;
	int                       mismatches = 0;
	int                       cycles = 0;

	logic [31:0]              fixed_low [6] = '{32'hFFFF_FFFF, 32'h0, 32'h04C1_1DB7,
		32'h0, 32'hFFFF_FFFF, 32'h1021};
	logic [DGB-1:0]           fixed_degree [6] = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63, 6'd16};

	crc_encode_and_check DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] gf2_remainder(input logic [63:0] dividend, input int d,
		input logic [63:0] low);
		logic [63:0] mask;
		logic [63:0] rem;
		logic        top;
		mask = (64'd1 << d) - 64'd1;
		rem = '0;
		low = low & mask;
		for (int i = 63; i >= 0; i--) begin
			top = rem[d-1];
			rem = ((rem << 1) | dividend[i]) & mask;
			if (top) begin
				rem = rem ^ low;
			end
		end
		return rem;
	endfunction

	function automatic crc_ec_pkg::out_t crc_result(input crc_ec_pkg::in_t beat);
		crc_ec_pkg::out_t r;
		int               d;
		logic [63:0]      dmask;
		logic [63:0]      shifted;
		logic [63:0]      rem;
		d = cfg_degree;
		if (d < 1) begin
			d = 1;
		end
		if (d > DEG_MAX) begin
			d = DEG_MAX;
		end
		dmask = (64'd1 << DATA_W) - 64'd1;
		if (beat.cmd == crc_ec_pkg::CMD_ENCODE) begin
			shifted = (beat.word_in & dmask) << d;
			rem = gf2_remainder(shifted, d, {32'd0, cfg_low_terms});
			r.codeword = shifted | rem;
			r.remainder = rem[31:0];
			r.error_flag = 1'b0;
			r.too_wide = (beat.word_in & ~dmask) != 64'd0;
		end else begin
			rem = gf2_remainder(beat.word_in, d, {32'd0, cfg_low_terms});
			r.codeword = '0;
			r.remainder = rem[31:0];
			r.error_flag = rem != 64'd0;
			r.too_wide = 1'b0;
		end
		return r;
	endfunction

	task automatic push_word(input logic cmd, input logic [63:0] word);
		crc_ec_pkg::in_t beat;
		beat.cmd = cmd;
		beat.word_in = word;
		pending_words.push_back(beat);
	endtask

	function automatic logic [63:0] codeword_of(input logic [63:0] data);
		crc_ec_pkg::in_t  beat;
		crc_ec_pkg::out_t r;
		beat.cmd = crc_ec_pkg::CMD_ENCODE;
		beat.word_in = data;
		r = crc_result(beat);
		return r.codeword;
	endfunction

	task automatic push_edges();
		push_word(crc_ec_pkg::CMD_ENCODE, 64'd0);
		push_word(crc_ec_pkg::CMD_ENCODE, '1);
		push_word(crc_ec_pkg::CMD_CHECK, 64'd0);
		push_word(crc_ec_pkg::CMD_CHECK, '1);
	endtask

	// half in-range data or valid codewords, the rest corrupted codewords or noise
	task automatic push_random(input int count);
		logic [63:0] word;
		int          pick;
		for (int n = 0; n < count; n++) begin
			word = {$urandom, $urandom};
			pick = $urandom_range(0, 3);
			if ($urandom_range(0, 1) == 0) begin
				if (pick != 0) begin
					word = word & ((64'd1 << DATA_W) - 64'd1);
				end
				push_word(crc_ec_pkg::CMD_ENCODE, word);
			end else begin
				if (pick <= 1) begin
					word = codeword_of(word & ((64'd1 << DATA_W) - 64'd1));
					if (pick == 1) begin
						word[$urandom_range(0, 63)] ^= 1'b1;
					end
				end
				push_word(crc_ec_pkg::CMD_CHECK, word);
			end
		end
	endtask

	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {reg_sel, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (reg_sel == crc_ec_pkg::REG_GEN_LOW) begin
			cfg_low_terms = value;
		end else begin
			cfg_degree = value[DGB-1:0];
		end
	endtask

	// sender holds off until the pipeline is empty
	task automatic drain();
		while (pending_words.size() != 0 || in_valid || crc_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				in_data <= pending_words.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < idle_pct);
	end

	// monitor and predictor
	always @(posedge clk) begin
		crc_ec_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (crc_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat %h", out_data);
				end
			end else begin
				want = crc_expected.pop_front();
				if (out_data.codeword !== want.codeword || out_data.remainder !== want.remainder
					|| out_data.error_flag !== want.error_flag
					|| out_data.too_wide !== want.too_wide) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result beat: codeword exp %h got %h, remainder exp %h got %h",
							want.codeword, out_data.codeword, want.remainder, out_data.remainder);
						$display("  error_flag exp %b got %b, too_wide exp %b got %b",
							want.error_flag, out_data.error_flag, want.too_wide,
							out_data.too_wide);
					end
				end
			end
		end
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			crc_expected.push_back(crc_result(in_data));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("crc_encode_and_check: mismatch");
			$finish;
		end
	end

	initial begin
		logic [63:0] word;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset generator x^8 + x^2 + x + 1
		push_word(crc_ec_pkg::CMD_ENCODE, 64'd0);
		push_word(crc_ec_pkg::CMD_ENCODE, 64'd1);
		push_word(crc_ec_pkg::CMD_ENCODE, 64'hFFFF_FFFF);
		push_word(crc_ec_pkg::CMD_ENCODE, '1);
		push_word(crc_ec_pkg::CMD_ENCODE, 64'h1_0000_0000);
		push_word(crc_ec_pkg::CMD_ENCODE, 64'h8000_0000_0000_0000);
		push_word(crc_ec_pkg::CMD_ENCODE, 64'h8000_0000);
		push_word(crc_ec_pkg::CMD_CHECK, 64'd0);
		push_word(crc_ec_pkg::CMD_CHECK, 64'd1);
		push_word(crc_ec_pkg::CMD_CHECK, '1);
		push_word(crc_ec_pkg::CMD_CHECK, 64'h8000_0000_0000_0000);
		word = codeword_of(64'h1234_5678);
		push_word(crc_ec_pkg::CMD_CHECK, word);
		push_word(crc_ec_pkg::CMD_CHECK, word ^ 64'd1);
		push_word(crc_ec_pkg::CMD_CHECK, codeword_of(64'hFFFF_FFFF));
		push_word(crc_ec_pkg::CMD_CHECK, 64'h107);
		push_word(crc_ec_pkg::CMD_CHECK, 64'h100);
		push_word(crc_ec_pkg::CMD_CHECK, 64'h7);
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p < 6) begin
				write_reg(crc_ec_pkg::REG_GEN_LOW, fixed_low[p]);
				write_reg(crc_ec_pkg::REG_GEN_DEGREE, {26'd0, fixed_degree[p]});
			end else begin
				write_reg(crc_ec_pkg::REG_GEN_LOW, $urandom);
				write_reg(crc_ec_pkg::REG_GEN_DEGREE, $urandom_range(0, 63));
			end
			idle_pct = (p == 2) ? 0 : 26;
			push_edges();
			push_random(PHASE_BEATS);
			drain();
		end

		if (mismatches == 0) begin
			$display("crc_encode_and_check: match");
		end else begin
			$display("crc_encode_and_check: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
design/crc_ec_pkg.sv
design/crc_ec_div_stage.sv
design/crc_encode_and_check.sv
sim/tb.sv
